[src/rlth_pkg.sv]
// Shared types, constants and the message classifier for the report link target.
// Depends on nothing; every other file of the block imports it.
package rlth_pkg;

  localparam int RECEIVE_DEPTH_DEF = 18;
  localparam int PAD_LEN           = 18;
  localparam int STATUS_LEN        = 3;
  localparam int REPLY_DEPTH       = 4;
  localparam int REPLY_AW          = $clog2(REPLY_DEPTH);
  localparam int REPLY_NW          = $clog2(REPLY_DEPTH + 1);
  localparam int RX_IDX_W          = $clog2(PAD_LEN);

  localparam logic [7:0] ID_PAD        = 8'd1;
  localparam logic [7:0] ID_STATUS     = 8'd2;
  localparam logic [7:0] ID_CONNECT    = 8'd3;
  localparam logic [7:0] ID_DISCONNECT = 8'd4;

  localparam logic [7:0] ST_NOT_READY = 8'd1;
  localparam logic [7:0] ST_READY     = 8'd2;
  localparam logic [7:0] ST_RESP_OK   = 8'd3;

  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] KIND_FINISH = 2'd0;
  localparam logic [1:0] KIND_PAD    = 2'd1;
  localparam logic [1:0] KIND_TX     = 2'd2;

  typedef logic [PAD_LEN-1:0][7:0] rx_bytes_t;
  typedef logic [REPLY_DEPTH-1:0][7:0] reply_bytes_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_PAD,
    CLS_STATUS,
    CLS_CONNECT,
    CLS_DISCONNECT
  } msg_class_t;

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_WRITE = 3'b010,
    SEQ_READ  = 3'b100
  } seq_state_t;

  // Receive store control, top level to store.
  typedef struct packed {
    logic wr_en;
    logic clear;
    logic flush;
  } rx_ctrl_t;

  // One access of the single-port reply memory.
  typedef struct packed {
    logic                we;
    logic                re;
    logic [REPLY_AW-1:0] addr;
    logic [7:0]          wdata;
  } mem_req_t;

  function automatic msg_class_t classify(input logic [7:0] len, input logic [7:0] id);
    msg_class_t cls;
    cls = CLS_NONE;
    if (id == ID_PAD && len == 8'(PAD_LEN)) begin
      cls = CLS_PAD;
    end else if (len == 8'(STATUS_LEN)) begin
      if (id == ID_STATUS) begin
        cls = CLS_STATUS;
      end else if (id == ID_CONNECT) begin
        cls = CLS_CONNECT;
      end else if (id == ID_DISCONNECT) begin
        cls = CLS_DISCONNECT;
      end
    end
    return cls;
  endfunction

endpackage

[src/rlth_rx_store.sv]
// Receive store: incoming message bytes and the fill count.
// Depends on rlth_pkg.
module rlth_rx_store
  import rlth_pkg::*;
#(
  parameter int RECEIVE_DEPTH = RECEIVE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rx_ctrl_t  ctrl,
  input  logic [7:0] wr_data,
  output rx_bytes_t bytes
);

  localparam int CW = $clog2(RECEIVE_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  rx_bytes_t     bytes_r, bytes_nxt;
  logic          room;

  // Bytes past the decoded frame only advance the count; nothing reads them.
  assign room = (count_r < CW'(RECEIVE_DEPTH));

  always_comb begin
    count_nxt = count_r;
    bytes_nxt = bytes_r;
    if (ctrl.clear) begin
      bytes_nxt = '0;
    end
    if (ctrl.flush) begin
      count_nxt = '0;
    end else if (ctrl.wr_en && room) begin
      count_nxt = count_r + CW'(1);
      if (count_r < CW'(PAD_LEN)) begin
        bytes_nxt[count_r[RX_IDX_W-1:0]] = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bytes_r <= '0;
    end else begin
      count_r <= count_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  assign bytes = bytes_r;

endmodule

[src/rlth_reply_mem.sv]
// Reply store: single-port memory with registered read and per-entry valid bits.
// Depends on rlth_pkg.
module rlth_reply_mem
  import rlth_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0]             mem [REPLY_DEPTH];
  logic [REPLY_DEPTH-1:0] vld_r;
  logic [7:0]             q_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Hold the read data until the next read; unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (req.re) begin
      q_r <= vld_r[req.addr] ? mem[req.addr] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  assign rdata = q_r;

endmodule

[src/report_link_target_handler.sv]
// Report link target: event intake, message decode, reply sequencer, result register.
// Depends on rlth_pkg, rlth_rx_store and rlth_reply_mem.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   in_     | input     | in_valid / in_stall   | opcode, rx_byte, host_mounted, rumble_*
//   out_    | output    | out_valid / out_stall | result_kind, tx_byte, last_byte, link, pad
//
// A receive beat never stalls. A finish beat leaves one result; a recognized message
// writes its 3 (request classes) or 4 (pad) reply bytes one per cycle from the
// accepting edge on, and the next finish or request waits behind the last of them.
// A read request sweeps the reply memory, one address per cycle unless out_stall
// holds the read; each byte passes the memory read register, then the result register.
// Reset: synchronous, no clearing pass (the reply memory has valid bits).
// Stalls: out_stall holds the result register and the read in flight; finish and
// request beats wait while the reply memory or the result register is busy.
module report_link_target_handler
  import rlth_pkg::*;
#(
  parameter int RECEIVE_DEPTH = RECEIVE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_host_mounted,
  input  logic [7:0]         in_rumble_left,
  input  logic [7:0]         in_rumble_right,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_last_byte,
  output logic               out_link_enabled,
  output logic [15:0]        out_buttons,
  output logic [7:0]         out_dpad,
  output logic [15:0]        out_triggers,
  output logic signed [15:0] out_stick_left_x,
  output logic signed [15:0] out_stick_left_y,
  output logic signed [15:0] out_stick_right_x,
  output logic signed [15:0] out_stick_right_y,
  output logic [23:0]        out_chatpad_keys
);

  // ---------------------------------------------------------------------------
  // Sequencer and pipeline state
  // ---------------------------------------------------------------------------
  seq_state_t          state_r, state_nxt;
  logic                link_r, link_nxt;
  logic [REPLY_AW-1:0] wr_idx_r, wr_idx_nxt;    // next reply byte to write
  logic [REPLY_AW-1:0] wr_end_r, wr_end_nxt;    // last reply byte to write
  reply_bytes_t        wr_data_r, wr_data_nxt;
  logic [REPLY_AW-1:0] iss_idx_r, iss_idx_nxt;  // next reply address to read
  logic                rd_valid_r, rd_valid_nxt;
  logic [REPLY_AW-1:0] rd_idx_r, rd_idx_nxt;    // address whose data sits in the memory
  logic [REPLY_NW-1:0] n_r, n_nxt;              // saturated reply length

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [7:0]         out_tx_r, out_tx_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_link_r, out_link_nxt;
  logic [15:0]        out_buttons_r, out_buttons_nxt;
  logic [7:0]         out_dpad_r, out_dpad_nxt;
  logic [15:0]        out_trig_r, out_trig_nxt;
  logic signed [15:0] out_lx_r, out_lx_nxt;
  logic signed [15:0] out_ly_r, out_ly_nxt;
  logic signed [15:0] out_rx_r, out_rx_nxt;
  logic signed [15:0] out_ry_r, out_ry_nxt;
  logic [23:0]        out_keys_r, out_keys_nxt;

  // ---------------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------------
  rx_ctrl_t   rx_ctrl;
  rx_bytes_t  rx_bytes;
  mem_req_t   mem_req;
  logic [7:0] mem_q;

  rlth_rx_store #(
    .RECEIVE_DEPTH(RECEIVE_DEPTH)
  ) u_rx_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (rx_ctrl),
    .wr_data(in_rx_byte),
    .bytes  (rx_bytes)
  );

  rlth_reply_mem u_reply_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mem_req),
    .rdata(mem_q)
  );

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic out_free;   // result register can load this cycle
  logic rd_move;    // read data leaves the memory register this cycle
  logic idle;
  logic in_acc, fin_acc, req_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign rd_move  = rd_valid_r && out_free;
  assign idle     = (state_r == SEQ_IDLE);

  // Finish owns the result register for its cycle, so no read may be in flight.
  // A request may start as soon as the previous request's last read drains.
  always_comb begin
    case (in_opcode)
      OP_FINISH:  in_stall = !(idle && !rd_valid_r && out_free);
      OP_REQUEST: in_stall = !(idle && (!rd_valid_r || rd_move));
      default:    in_stall = 1'b0;
    endcase
  end

  assign in_acc  = in_valid && !in_stall;
  assign fin_acc = in_acc && (in_opcode == OP_FINISH);
  assign req_acc = in_acc && (in_opcode == OP_REQUEST);

  assign rx_ctrl.wr_en = in_acc && (in_opcode == OP_RX);
  assign rx_ctrl.clear = req_acc;
  assign rx_ctrl.flush = fin_acc;

  // ---------------------------------------------------------------------------
  // Message decode
  // ---------------------------------------------------------------------------
  msg_class_t   cls;
  reply_bytes_t reply_bytes;
  logic [7:0]   status_byte;

  assign cls = classify(rx_bytes[0], rx_bytes[1]);

  always_comb begin
    status_byte = ST_RESP_OK;
    if (cls == CLS_STATUS) begin
      status_byte = in_host_mounted ? ST_NOT_READY : ST_READY;
    end
    if (cls == CLS_PAD) begin
      reply_bytes = {in_rumble_right, in_rumble_left, ID_PAD, 8'(REPLY_DEPTH)};
    end else begin
      // Request classes leave the fourth byte alone; it is never written.
      reply_bytes = {8'd0, status_byte, ID_STATUS, 8'(STATUS_LEN)};
    end
  end

  always_comb begin
    link_nxt = link_r;
    if (fin_acc && cls == CLS_CONNECT) begin
      link_nxt = 1'b1;
    end else if (fin_acc && cls == CLS_DISCONNECT) begin
      link_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Reply memory access: one write or one read per cycle. Writes of a finish
  // complete before any request reads, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic issue_ok;

  assign issue_ok = !rd_valid_r || rd_move;

  always_comb begin
    mem_req = '0;
    if (fin_acc && cls != CLS_NONE) begin
      mem_req.we    = 1'b1;
      mem_req.wdata = reply_bytes[0];
    end else if (req_acc) begin
      mem_req.re = 1'b1;
    end else if (state_r == SEQ_WRITE) begin
      mem_req.we    = 1'b1;
      mem_req.addr  = wr_idx_r;
      mem_req.wdata = wr_data_r[wr_idx_r];
    end else if (state_r == SEQ_READ && issue_ok) begin
      mem_req.re   = 1'b1;
      mem_req.addr = iss_idx_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wr_idx_nxt  = wr_idx_r;
    wr_end_nxt  = wr_end_r;
    wr_data_nxt = wr_data_r;
    iss_idx_nxt = iss_idx_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (fin_acc && cls != CLS_NONE) begin
          state_nxt   = SEQ_WRITE;
          wr_idx_nxt  = REPLY_AW'(1);
          wr_end_nxt  = (cls == CLS_PAD) ? REPLY_AW'(REPLY_DEPTH - 1) : REPLY_AW'(STATUS_LEN - 1);
          wr_data_nxt = reply_bytes;
        end else if (req_acc) begin
          state_nxt   = SEQ_READ;
          iss_idx_nxt = REPLY_AW'(1);
        end
      end
      SEQ_WRITE: begin
        wr_idx_nxt = wr_idx_r + REPLY_AW'(1);
        if (wr_idx_r == wr_end_r) begin
          state_nxt = SEQ_IDLE;
        end
      end
      SEQ_READ: begin
        if (issue_ok) begin
          iss_idx_nxt = iss_idx_r + REPLY_AW'(1);
          if (iss_idx_r == REPLY_AW'(REPLY_DEPTH - 1)) begin
            state_nxt = SEQ_IDLE;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Read return: the length comes with the first byte; drop bytes past it.
  // ---------------------------------------------------------------------------
  logic [REPLY_NW-1:0] n_first, n_eff;
  logic                tx_emit, tx_last;

  assign n_first = (mem_q > 8'(REPLY_DEPTH)) ? REPLY_NW'(REPLY_DEPTH) : mem_q[REPLY_NW-1:0];
  assign n_eff   = (rd_idx_r == '0) ? n_first : n_r;
  assign tx_emit = rd_move && ({1'b0, rd_idx_r} < n_eff);
  assign tx_last = ({1'b0, rd_idx_r} + REPLY_NW'(1)) == n_eff;

  assign rd_valid_nxt = mem_req.re ? 1'b1 : (rd_move ? 1'b0 : rd_valid_r);
  assign rd_idx_nxt   = mem_req.re ? mem_req.addr : rd_idx_r;
  assign n_nxt        = (rd_move && rd_idx_r == '0) ? n_first : n_r;

  // ---------------------------------------------------------------------------
  // Result register load
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_kind_nxt    = out_kind_r;
    out_tx_nxt      = out_tx_r;
    out_last_nxt    = out_last_r;
    out_link_nxt    = out_link_r;
    out_buttons_nxt = out_buttons_r;
    out_dpad_nxt    = out_dpad_r;
    out_trig_nxt    = out_trig_r;
    out_lx_nxt      = out_lx_r;
    out_ly_nxt      = out_ly_r;
    out_rx_nxt      = out_rx_r;
    out_ry_nxt      = out_ry_r;
    out_keys_nxt    = out_keys_r;
    if (fin_acc || tx_emit) begin
      out_valid_nxt   = 1'b1;
      out_tx_nxt      = '0;
      out_last_nxt    = 1'b0;
      out_buttons_nxt = '0;
      out_dpad_nxt    = '0;
      out_trig_nxt    = '0;
      out_lx_nxt      = '0;
      out_ly_nxt      = '0;
      out_rx_nxt      = '0;
      out_ry_nxt      = '0;
      out_keys_nxt    = '0;
      if (fin_acc) begin
        out_link_nxt = link_nxt;
        out_kind_nxt = (cls == CLS_PAD) ? KIND_PAD : KIND_FINISH;
        if (cls == CLS_PAD) begin
          out_buttons_nxt = {rx_bytes[3], rx_bytes[2]};
          out_dpad_nxt    = rx_bytes[4];
          out_trig_nxt    = {rx_bytes[6], rx_bytes[5]};
          out_lx_nxt      = {rx_bytes[8], rx_bytes[7]};
          out_ly_nxt      = {rx_bytes[10], rx_bytes[9]};
          out_rx_nxt      = {rx_bytes[12], rx_bytes[11]};
          out_ry_nxt      = {rx_bytes[14], rx_bytes[13]};
          out_keys_nxt    = {rx_bytes[17], rx_bytes[16], rx_bytes[15]};
        end
      end else begin
        out_link_nxt = link_r;
        out_kind_nxt = KIND_TX;
        out_tx_nxt   = mem_q;
        out_last_nxt = tx_last;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      link_r      <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      link_r      <= link_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r      <= wr_idx_nxt;
    wr_end_r      <= wr_end_nxt;
    wr_data_r     <= wr_data_nxt;
    iss_idx_r     <= iss_idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    n_r           <= n_nxt;
    out_kind_r    <= out_kind_nxt;
    out_tx_r      <= out_tx_nxt;
    out_last_r    <= out_last_nxt;
    out_link_r    <= out_link_nxt;
    out_buttons_r <= out_buttons_nxt;
    out_dpad_r    <= out_dpad_nxt;
    out_trig_r    <= out_trig_nxt;
    out_lx_r      <= out_lx_nxt;
    out_ly_r      <= out_ly_nxt;
    out_rx_r      <= out_rx_nxt;
    out_ry_r      <= out_ry_nxt;
    out_keys_r    <= out_keys_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_tx_byte       = out_tx_r;
  assign out_last_byte     = out_last_r;
  assign out_link_enabled  = out_link_r;
  assign out_buttons       = out_buttons_r;
  assign out_dpad          = out_dpad_r;
  assign out_triggers      = out_trig_r;
  assign out_stick_left_x  = out_lx_r;
  assign out_stick_left_y  = out_ly_r;
  assign out_stick_right_x = out_rx_r;
  assign out_stick_right_y = out_ry_r;
  assign out_chatpad_keys  = out_keys_r;

`ifndef NO_ASSERTIONS
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("reply memory written and read in one cycle");

  a_finish_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    fin_acc |-> !rd_valid_r)
    else $error("finish accepted with a reply read in flight");

  a_write_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_WRITE && in_acc) |-> (in_opcode == OP_RX || in_opcode == OP_NONE))
    else $error("finish or request accepted during reply write");

  a_stalled_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid_r && !out_free) |=> (rd_valid_r && $stable(rd_idx_r) && $stable(mem_q)))
    else $error("read data lost while the result register is held");
`endif

endmodule
